/* sv/rstat_pkg.sv */
// shared types and constants for the running statistics block
package rstat_pkg;

  localparam int unsigned MAX_COUNT   = 65535;
  localparam logic [15:0] COUNT_LIMIT = 16'(MAX_COUNT);
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned SQRT_STEPS  = 16;

  // snapshot of the statistics after one transaction
  typedef struct packed {
    logic signed [15:0] least;
    logic signed [15:0] greatest;
    logic signed [32:0] sum;
    logic        [46:0] sqsum;
    logic        [15:0] count;
    logic               full;
  } snap_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_DIFF,
    BK_DIV,
    BK_SQRT,
    BK_EMIT
  } back_state_t;

endpackage

/* sv/rstat_front.sv */
// front part: takes samples and updates min, max, sums and count
module rstat_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic signed [15:0]    sample,
  output rstat_pkg::snap_t      snap
);
  import rstat_pkg::*;

  logic signed [15:0] least, least_next;
  logic signed [15:0] greatest, greatest_next;
  logic signed [32:0] sum, sum_next;
  logic        [46:0] sqsum, sqsum_next;
  logic        [15:0] count, count_next;
  logic               full;
  logic signed [31:0] sq;

  always_comb begin
    full          = (count >= COUNT_LIMIT);
    sq            = sample * sample;
    least_next    = least;
    greatest_next = greatest;
    sum_next      = sum;
    sqsum_next    = sqsum;
    count_next    = count;
    if (!full) begin
      // first sample seeds both extremes
      if (count == 16'd0 || sample < least) begin
        least_next = sample;
      end
      if (count == 16'd0 || sample > greatest) begin
        greatest_next = sample;
      end
      sum_next   = sum + {{17{sample[15]}}, sample};
      sqsum_next = sqsum + {15'd0, sq};
      count_next = count + 16'd1;
    end
  end

  always_comb begin
    snap.least    = least_next;
    snap.greatest = greatest_next;
    snap.sum      = sum_next;
    snap.sqsum    = sqsum_next;
    snap.count    = count_next;
    snap.full     = full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least    <= '0;
      greatest <= '0;
      sum      <= '0;
      sqsum    <= '0;
      count    <= '0;
    end else if (accept) begin
      least    <= least_next;
      greatest <= greatest_next;
      sum      <= sum_next;
      sqsum    <= sqsum_next;
      count    <= count_next;
    end
  end

endmodule

/* sv/rstat_fifo.sv */
// short queue of statistics snapshots between front and back
module rstat_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rstat_pkg::snap_t wdata,
  input  logic             pop,
  output rstat_pkg::snap_t rdata,
  output logic             not_empty,
  output logic             full
);
  import rstat_pkg::*;

  snap_t               entries [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     fill;

  assign rdata     = entries[rptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == (QPTR_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* sv/rstat_div.sv */
// restoring divider, one quotient bit per step
module rstat_div (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient
);
  import rstat_pkg::*;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;

  assign rem_shift = {rem, quotient[63]};
  assign rem_sub   = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (step) begin
      if (rem_shift >= {1'b0, dvs}) begin
        rem      <= rem_sub[31:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= rem_shift[31:0];
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

/* sv/rstat_back.sv */
// back part: mean, variance division, square root and output register
module rstat_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rstat_pkg::snap_t  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [15:0] min_value,
  output logic signed [15:0] max_value,
  output logic signed [15:0] mean_value,
  output logic        [15:0] std_value,
  output logic        [15:0] sample_count,
  output logic               full_flag
);
  import rstat_pkg::*;

  back_state_t state, state_next;
  snap_t       snap;
  logic [31:0] mag;
  logic [38:0] p_lo;
  logic [38:0] p_hi;
  logic [61:0] bsq;
  logic [31:0] nn;
  logic [61:0] prod_a;
  logic [5:0]  step_cnt;
  logic [31:0] rad;
  logic [31:0] rad_cur;
  logic [17:0] sq_rem;
  logic [15:0] root;
  logic [63:0] var_q;
  logic [63:0] mean_q;
  logic [63:0] diff;
  logic [19:0] sq_shift;
  logic [19:0] sq_trial;
  logic [31:0] mean_s;
  logic [32:0] sum_abs;
  logic        div_load, div_step, sq_step, emit;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = BK_MUL;
      BK_MUL:  state_next = BK_ADD;
      BK_ADD:  state_next = BK_DIFF;
      BK_DIFF: state_next = BK_DIV;
      BK_DIV:  if (step_cnt == 6'(DIV_STEPS - 1)) state_next = BK_SQRT;
      BK_SQRT: if (step_cnt == 6'(SQRT_STEPS - 1)) state_next = BK_EMIT;
      BK_EMIT: if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    sq_step  = 1'b0;
    emit     = 1'b0;
    case (state)
      BK_IDLE: q_pop    = q_valid;
      BK_DIFF: div_load = 1'b1;
      BK_DIV:  div_step = 1'b1;
      BK_SQRT: sq_step  = 1'b1;
      BK_EMIT: emit     = !out_valid || out_ready;
      default: q_pop    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sum_abs = q_data.sum[32] ? -q_data.sum : q_data.sum;
  assign diff    = (prod_a > bsq) ? {2'b00, prod_a - bsq} : 64'd0;

  rstat_div u_var_div (
    .clk      (clk),
    .load     (div_load),
    .step     (div_step),
    .dividend (diff),
    .divisor  (nn),
    .quotient (var_q)
  );

  rstat_div u_mean_div (
    .clk      (clk),
    .load     (div_load),
    .step     (div_step),
    .dividend ({32'd0, mag}),
    .divisor  ({16'd0, snap.count}),
    .quotient (mean_q)
  );

  // first root step takes the finished variance straight from the divider
  assign rad_cur  = (step_cnt == 6'd0) ? var_q[31:0] : rad;
  assign sq_shift = {sq_rem, rad_cur[31:30]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign mean_s   = snap.sum[32] ? -mean_q[31:0] : mean_q[31:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      snap <= q_data;
      mag  <= sum_abs[31:0];
    end
    if (state == BK_MUL) begin
      p_lo <= snap.count * snap.sqsum[22:0];
      p_hi <= snap.count * snap.sqsum[45:23];
      bsq  <= mag[30:0] * mag[30:0];
      nn   <= snap.count * snap.count;
    end
    if (state == BK_ADD) begin
      prod_a <= {23'd0, p_lo} + {p_hi[38:0], 23'd0};
    end
    if (div_load || (div_step && step_cnt == 6'(DIV_STEPS - 1))) begin
      step_cnt <= '0;
    end else if (div_step || sq_step) begin
      step_cnt <= step_cnt + 6'd1;
    end
    if (div_step && step_cnt == 6'(DIV_STEPS - 1)) begin
      sq_rem <= '0;
      root   <= '0;
    end else if (sq_step) begin
      rad <= {rad_cur[29:0], 2'b00};
      if (sq_shift >= sq_trial) begin
        sq_rem <= 18'(sq_shift - sq_trial);
        root   <= {root[14:0], 1'b1};
      end else begin
        sq_rem <= sq_shift[17:0];
        root   <= {root[14:0], 1'b0};
      end
    end
  end

  // output register: a finished result waits here while the next one runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      min_value    <= snap.least;
      max_value    <= snap.greatest;
      mean_value   <= mean_s[15:0];
      std_value    <= root;
      sample_count <= snap.count;
      full_flag    <= snap.full;
    end
  end

endmodule

/* sv/running_statistics.sv */
// top level of the running statistics block
//
//  channel   ports                                   dir  accepted when
//  input     in_valid, in_ready, sample              in   in_valid && in_ready
//  result    out_valid, out_ready, min_value,        out  out_valid && out_ready
//            max_value, mean_value, std_value,
//            sample_count, full_flag
//
// each transaction in the back part passes through the states idle, multiply,
// add and difference, 64 divider steps (variance and mean dividers run side by
// side) and 16 square root steps, and then loads the output register
// the front updates the running sums in the cycle a sample is taken and queues a
// snapshot; it stalls only when the two-entry queue is full
// rst is synchronous; all statistics clear to zero and the queue empties
// a stalled result sits in the output register while the next one is computed
module running_statistics (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] min_value,
  output logic signed [15:0] max_value,
  output logic signed [15:0] mean_value,
  output logic        [15:0] std_value,
  output logic        [15:0] sample_count,
  output logic               full_flag
);
  import rstat_pkg::*;

  snap_t front_snap;
  snap_t q_data;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  accept;

  // take a sample whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  rstat_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .snap   (front_snap)
  );

  // snapshot queue decouples sample intake from the long back computation
  rstat_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .wdata     (front_snap),
    .pop       (q_pop),
    .rdata     (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  rstat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .min_value    (min_value),
    .max_value    (max_value),
    .mean_value   (mean_value),
    .std_value    (std_value),
    .sample_count (sample_count),
    .full_flag    (full_flag)
  );

  // count never passes the limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count <= COUNT_LIMIT)
    else $error("sample count beyond limit");

  // a full result only comes with the count at the limit
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_flag |-> sample_count == COUNT_LIMIT)
    else $error("full flag without count at limit");

  // extremes stay ordered once a sample has been taken
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count != 16'd0 |-> min_value <= max_value)
    else $error("min above max");

endmodule
